### rtl/fupd_pkg.sv
// Package for the file URI percent decoder.
// Holds the parse phase and status codes, stream widths, and the character
// tables and hex helper used by the decoder core. No dependencies.
package fupd_pkg;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 1;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_HOST,
		PH_LOCAL,
		PH_PATH,
		PH_ESC1,
		PH_ESC2,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_FILE,
		ST_NOT_ABS,
		ST_QUERY,
		ST_INCOMPLETE,
		ST_BAD_HEX,
		ST_NUL
	} status_t;

	localparam logic [3:0] SCHEME_LEN = 4'd7;
	localparam logic [3:0] HOST_LEN   = 4'd10;

	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_L       = 8'h6c;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_QUERY   = 8'h3f;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// Characters of "file://".
	function automatic logic [7:0] scheme_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h66;
			3'd1: c = 8'h69;
			3'd2: c = 8'h6c;
			3'd3: c = 8'h65;
			3'd4: c = 8'h3a;
			3'd5: c = 8'h2f;
			3'd6: c = 8'h2f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of "localhost/".
	function automatic logic [7:0] host_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h6c;
			4'd1: c = 8'h6f;
			4'd2: c = 8'h63;
			4'd3: c = 8'h61;
			4'd4: c = 8'h6c;
			4'd5: c = 8'h68;
			4'd6: c = 8'h6f;
			4'd7: c = 8'h73;
			4'd8: c = 8'h74;
			4'd9: c = 8'h2f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Returns {valid, nibble} for one ASCII hex digit of either case.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		r = 5'd0;
		d = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			r = {1'b1, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			r = {1'b1, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

### rtl/file_uri_percent_decoder.sv
// Top level of the file URI percent decoder: stream in, stream out.
// Depends on fupd_pkg for phase and status codes, character tables and
// the hex digit helper.
//
// The block takes one URI byte per transfer (tlast on the final byte) and
// accepts a new byte in every cycle as long as the output side keeps up. A
// byte is registered on entry, the parser state update and percent decode
// run between that register and the result register, which presents the
// result. Each decoded path
// byte leaves as its own transfer with tuser set; the final byte always
// gives a transfer with tlast set, whose tdata carries the status (zero for
// a good local absolute file URI). Bytes that complete nothing, such as
// prefix characters and the percent sign, give no transfer. The loop through
// the parser state is what sets the rate of one byte a cycle.
module file_uri_percent_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fupd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
	input  logic                             s_tlast,   // last
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fupd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [10:8] status
	output logic [fupd_pkg::OUT_TUSER_W-1:0] m_tuser,   // [0] byte_valid
	output logic                             m_tlast    // done_res
);
	import fupd_pkg::*;

	// Input stage.
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state.
	phase_t     phase_q, phase_nx;
	logic [3:0] pos_q, pos_nx;
	logic [7:0] digit_q, digit_nx;
	status_t    dec_err_q, dec_err_nx;
	logic       saw_q_q, saw_q_nx;
	status_t    early_q, early_nx;

	// Result register.
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_bvalid_q;
	logic       out_last_q;
	status_t    out_status_q;

	logic       have;
	logic [7:0] val;
	status_t    status;
	logic       emit;
	logic       adv;

	logic [4:0] hi_hex, lo_hex;
	logic [7:0] esc_val;
	logic       esc_ok;
	logic       is_query;

	assign hi_hex   = hex_nibble(digit_q);
	assign lo_hex   = hex_nibble(byte_s1);
	assign esc_ok   = hi_hex[4] & lo_hex[4];
	assign esc_val  = {hi_hex[3:0], lo_hex[3:0]};
	assign is_query = (byte_s1 == CH_QUERY) || (byte_s1 == CH_HASH);

	// Next state of the parser for the byte in the input stage.
	always_comb begin
		phase_nx   = phase_q;
		pos_nx     = pos_q;
		digit_nx   = digit_q;
		dec_err_nx = dec_err_q;
		saw_q_nx   = saw_q_q;
		early_nx   = early_q;
		case (phase_q)
			PH_PREFIX: begin
				if (pos_q < SCHEME_LEN && byte_s1 == scheme_char(pos_q[2:0])) begin
					pos_nx = pos_q + 4'd1;
					if (pos_q == SCHEME_LEN - 4'd1)
						phase_nx = PH_HOST;
				end else begin
					early_nx = ST_NOT_FILE;
					phase_nx = PH_DRAIN;
				end
			end
			PH_HOST: begin
				if (byte_s1 == CH_SLASH) begin
					phase_nx = PH_PATH;
				end else if (byte_s1 == CH_L) begin
					phase_nx = PH_LOCAL;
					pos_nx   = 4'd1;
				end else begin
					early_nx = ST_NOT_ABS;
					phase_nx = PH_DRAIN;
				end
			end
			PH_LOCAL: begin
				if (pos_q < HOST_LEN && byte_s1 == host_char(pos_q)) begin
					if (pos_q == HOST_LEN - 4'd1)
						phase_nx = PH_PATH;
					else
						pos_nx = pos_q + 4'd1;
				end else begin
					early_nx = ST_NOT_ABS;
					phase_nx = PH_DRAIN;
				end
			end
			PH_PATH, PH_ESC1, PH_ESC2: begin
				if (is_query)
					saw_q_nx = 1'b1;
				if (dec_err_q == ST_OK) begin
					if (phase_q == PH_PATH) begin
						if (byte_s1 == CH_PERCENT)
							phase_nx = PH_ESC1;
					end else if (phase_q == PH_ESC1) begin
						digit_nx = byte_s1;
						phase_nx = PH_ESC2;
					end else begin
						phase_nx = PH_PATH;
						if (!esc_ok)
							dec_err_nx = ST_BAD_HEX;
						else if (esc_val == CH_NUL)
							dec_err_nx = ST_NUL;
					end
				end
			end
			default: ;
		endcase
	end

	// Result for the byte in the input stage.
	always_comb begin
		have = 1'b0;
		val  = 8'd0;
		case (phase_q)
			PH_HOST: begin
				if (byte_s1 == CH_SLASH) begin
					have = 1'b1;
					val  = byte_s1;
				end
			end
			PH_LOCAL: begin
				if (pos_q == HOST_LEN - 4'd1 && byte_s1 == host_char(pos_q)) begin
					have = 1'b1;
					val  = byte_s1;
				end
			end
			PH_PATH: begin
				if (dec_err_q == ST_OK && byte_s1 != CH_PERCENT) begin
					have = 1'b1;
					val  = byte_s1;
				end
			end
			PH_ESC2: begin
				if (dec_err_q == ST_OK && esc_ok && esc_val != CH_NUL) begin
					have = 1'b1;
					val  = esc_val;
				end
			end
			default: ;
		endcase
		if (saw_q_nx || dec_err_nx != ST_OK || early_nx != ST_OK)
			have = 1'b0;

		if (early_nx != ST_OK)
			status = early_nx;
		else if (phase_nx == PH_PREFIX)
			status = ST_NOT_FILE;
		else if (phase_nx inside {PH_HOST, PH_LOCAL})
			status = ST_NOT_ABS;
		else if (saw_q_nx)
			status = ST_QUERY;
		else if (dec_err_nx != ST_OK)
			status = dec_err_nx;
		else if (phase_nx inside {PH_ESC1, PH_ESC2})
			status = ST_INCOMPLETE;
		else
			status = ST_OK;
		if (!last_s1)
			status = ST_OK;
		if (status != ST_OK)
			have = 1'b0;
		if (!have)
			val = 8'd0;
	end

	assign emit     = v_s1 && (have || last_s1);
	assign adv      = v_s1 && (!emit || !out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	// A last byte returns the parser to its reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			pos_q     <= 4'd0;
			digit_q   <= 8'd0;
			dec_err_q <= ST_OK;
			saw_q_q   <= 1'b0;
			early_q   <= ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				phase_q   <= PH_PREFIX;
				pos_q     <= 4'd0;
				digit_q   <= 8'd0;
				dec_err_q <= ST_OK;
				saw_q_q   <= 1'b0;
				early_q   <= ST_OK;
			end else begin
				phase_q   <= phase_nx;
				pos_q     <= pos_nx;
				digit_q   <= digit_nx;
				dec_err_q <= dec_err_nx;
				saw_q_q   <= saw_q_nx;
				early_q   <= early_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q   <= val;
			out_bvalid_q <= have;
			out_last_q   <= last_s1;
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_status_q, out_byte_q};
	assign m_tuser  = out_bvalid_q;
	assign m_tlast  = out_last_q;

	// A transfer that does not end the URI must carry a decoded byte.
	a_mid_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_last_q) |-> out_bvalid_q)
		else $error("result without byte before the last transfer");

	// Only the last transfer may carry a nonzero status.
	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_last_q) |-> (out_status_q == ST_OK))
		else $error("status reported before the last transfer");

	// A decoded byte is never delivered alongside an error status.
	a_byte_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_bvalid_q) |-> (out_status_q == ST_OK))
		else $error("decoded byte delivered with an error status");

	// After the last byte the parser starts over.
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (phase_q == PH_PREFIX && !saw_q_q && early_q == ST_OK))
		else $error("parser state not cleared after the last byte");

	// An early error always parks the parser in the drain phase.
	a_early_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(early_q != ST_OK) |-> (phase_q == PH_DRAIN))
		else $error("early error latched outside the drain phase");

endmodule
